### design/derrsa_pkg.sv
`default_nettype none

package derrsa_pkg;

	// Default key size limits.
	localparam int MODULUS_BYTES_DEF  = 512;
	localparam int EXPONENT_BYTES_DEF = 8;

	// DER tags that the parser checks.
	localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
	localparam logic [7:0] TAG_INTEGER    = 8'h02;
	localparam logic [7:0] TAG_BIT_STRING = 8'h03;
	localparam logic [7:0] TAG_VERSION    = 8'hA0;

	// Length octets: more than this many length bytes is rejected.
	localparam logic [6:0] MAX_LEN_BYTES = 7'd4;

	// Result beat kinds.
	localparam logic [1:0] KIND_MODULUS  = 2'd0;
	localparam logic [1:0] KIND_EXPONENT = 2'd1;
	localparam logic [1:0] KIND_STATUS   = 2'd2;

	// Status codes.
	localparam logic [2:0] STAT_OK           = 3'd0;
	localparam logic [2:0] STAT_BAD_TAG      = 3'd1;
	localparam logic [2:0] STAT_LONG_LENGTH  = 3'd2;
	localparam logic [2:0] STAT_TRUNCATED    = 3'd3;
	localparam logic [2:0] STAT_MOD_TOO_LONG = 3'd4;
	localparam logic [2:0] STAT_EXP_TOO_LONG = 3'd5;

	// Output queue geometry.
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_FILL_W = $clog2(OUT_DEPTH + 1);

	// One result beat.
	typedef struct packed {
		logic [1:0] item_kind;
		logic [7:0] key_byte;
		logic [8:0] byte_index;
		logic [2:0] status;
		logic [9:0] modulus_length;
		logic [3:0] exponent_length;
		logic       last_of_run;
	} result_t;

	// Write request from the parser into the output queue.
	typedef struct packed {
		logic    valid;
		result_t item;
	} push_t;

endpackage

`default_nettype wire

### design/derrsa_ifs.sv
`default_nettype none

// Byte stream channel into the extractor.
interface derrsa_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source(output valid, output data_byte, output end_of_message, input ready);
	modport sink(input valid, input data_byte, input end_of_message, output ready);
endinterface

// Result channel out of the extractor.
interface derrsa_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] item_kind;
	logic [7:0] key_byte;
	logic [8:0] byte_index;
	logic [2:0] status;
	logic [9:0] modulus_length;
	logic [3:0] exponent_length;
	logic       last_of_run;

	modport source(output valid, output item_kind, output key_byte, output byte_index,
		output status, output modulus_length, output exponent_length,
		output last_of_run, input ready);
	modport sink(input valid, input item_kind, input key_byte, input byte_index,
		input status, input modulus_length, input exponent_length,
		input last_of_run, output ready);
endinterface

`default_nettype wire

### design/derrsa_parser.sv
`default_nettype none

module derrsa_parser #(
	parameter int MODULUS_BYTES  = derrsa_pkg::MODULUS_BYTES_DEF,
	parameter int EXPONENT_BYTES = derrsa_pkg::EXPONENT_BYTES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	derrsa_byte_if.sink                           bytes,
	input  wire logic [derrsa_pkg::OUT_FILL_W-1:0] fill,
	output derrsa_pkg::push_t                     push
);

	localparam int MCW = $clog2(MODULUS_BYTES + 1);
	localparam int ECW = $clog2(EXPONENT_BYTES + 1);
	localparam logic [32:0] MOD_LIMIT = 33'(MODULUS_BYTES);
	localparam logic [32:0] EXP_LIMIT = 33'(EXPONENT_BYTES);

	typedef enum logic [4:0] {
		PH_LIST, PH_CLEN, PH_CERT_TAG, PH_TBS_TAG, PH_VER_TAG, PH_SKIP_TAG,
		PH_SPKI_TAG, PH_ALG_TAG, PH_BIT_TAG, PH_UNUSED, PH_RSA_TAG, PH_MOD_TAG,
		PH_MOD_DATA, PH_EXP_TAG, PH_EXP_DATA, PH_LEN_FIRST, PH_LEN_MORE,
		PH_SKIP_BODY, PH_DONE, PH_FAIL
	} phase_t;

	typedef enum logic [3:0] {
		OW_CERT, OW_TBS, OW_VER, OW_SKIP, OW_SPKI, OW_ALG, OW_BIT, OW_RSA,
		OW_MOD, OW_EXP
	} owner_t;

	// Input register.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eom_s1;

	// Parse state.
	phase_t      phase_q, phase_n;
	owner_t      owner_q, owner_n;
	logic [24:0] bc_q, bc_n;
	logic [23:0] dcl_q, dcl_n;
	logic [31:0] acc_q, acc_n;
	logic [2:0]  lbl_q, lbl_n;
	logic [31:0] skip_q, skip_n;
	logic [2:0]  stc_q, stc_n;
	logic [2:0]  err_q, err_n;
	logic [MCW-1:0] mcnt_q, mcnt_n;
	logic [ECW-1:0] ecnt_q, ecnt_n;

	// Status beat held back in a register when a key byte goes out with it.
	logic                pend_q, pend_n;
	derrsa_pkg::result_t pend_item_q, pend_item_n;

	logic accept;

	// Room for the beats of the byte in the input register and the new one.
	// No byte is taken while a byte that ends the message sits in the input register.
	assign bytes.ready = (fill <= derrsa_pkg::OUT_FILL_W'(derrsa_pkg::OUT_DEPTH - 3))
		&& !(valid_s1 && eom_s1);
	assign accept = bytes.valid && bytes.ready;

	// Per-byte parse step.
	always_comb begin
		logic        len_done;
		logic        skip_done;
		logic        fail_req;
		logic [2:0]  fail_code;
		logic        emitted;
		logic        too_long;
		logic [31:0] eff;
		logic [2:0]  st;
		logic [31:0] idx_wide;
		logic [31:0] mlen_wide;
		logic [31:0] elen_wide;
		derrsa_pkg::result_t status_item;

		phase_n     = phase_q;
		owner_n     = owner_q;
		bc_n        = bc_q;
		dcl_n       = dcl_q;
		acc_n       = acc_q;
		lbl_n       = lbl_q;
		skip_n      = skip_q;
		stc_n       = stc_q;
		err_n       = err_q;
		mcnt_n      = mcnt_q;
		ecnt_n      = ecnt_q;
		pend_n      = 1'b0;
		pend_item_n = pend_item_q;
		push        = '0;
		len_done    = 1'b0;
		skip_done   = 1'b0;
		fail_req    = 1'b0;
		fail_code   = derrsa_pkg::STAT_OK;
		emitted     = 1'b0;
		too_long    = 1'b0;
		eff         = acc_q;
		st          = derrsa_pkg::STAT_OK;
		idx_wide    = '0;
		mlen_wide   = '0;
		elen_wide   = '0;
		status_item = '0;

		// A held status beat goes out first; the input register is empty then.
		if (pend_q) begin
			push.valid = 1'b1;
			push.item  = pend_item_q;
		end

		if (valid_s1) begin
			bc_n = (&bc_q) ? bc_q : bc_q + 25'd1;

			unique case (phase_q)
				PH_LIST: begin
					if (bc_n >= 25'd3) phase_n = PH_CLEN;
				end
				PH_CLEN: begin
					dcl_n = {dcl_q[15:0], data_s1};
					if (bc_n >= 25'd6) phase_n = PH_CERT_TAG;
				end
				PH_CERT_TAG, PH_TBS_TAG, PH_SPKI_TAG, PH_RSA_TAG: begin
					if (data_s1 != derrsa_pkg::TAG_SEQUENCE) begin
						fail_req  = 1'b1;
						fail_code = derrsa_pkg::STAT_BAD_TAG;
					end else begin
						phase_n = PH_LEN_FIRST;
						if (phase_q == PH_CERT_TAG)      owner_n = OW_CERT;
						else if (phase_q == PH_TBS_TAG)  owner_n = OW_TBS;
						else if (phase_q == PH_SPKI_TAG) owner_n = OW_SPKI;
						else                             owner_n = OW_RSA;
					end
				end
				PH_BIT_TAG: begin
					if (data_s1 != derrsa_pkg::TAG_BIT_STRING) begin
						fail_req  = 1'b1;
						fail_code = derrsa_pkg::STAT_BAD_TAG;
					end else begin
						owner_n = OW_BIT;
						phase_n = PH_LEN_FIRST;
					end
				end
				PH_MOD_TAG, PH_EXP_TAG: begin
					if (data_s1 != derrsa_pkg::TAG_INTEGER) begin
						fail_req  = 1'b1;
						fail_code = derrsa_pkg::STAT_BAD_TAG;
					end else begin
						owner_n = (phase_q == PH_MOD_TAG) ? OW_MOD : OW_EXP;
						phase_n = PH_LEN_FIRST;
					end
				end
				PH_VER_TAG: begin
					owner_n = (data_s1 == derrsa_pkg::TAG_VERSION) ? OW_VER : OW_SKIP;
					phase_n = PH_LEN_FIRST;
				end
				PH_SKIP_TAG: begin
					owner_n = OW_SKIP;
					phase_n = PH_LEN_FIRST;
				end
				PH_ALG_TAG: begin
					owner_n = OW_ALG;
					phase_n = PH_LEN_FIRST;
				end
				PH_UNUSED: begin
					phase_n = PH_RSA_TAG;
				end
				PH_LEN_FIRST: begin
					if (!data_s1[7]) begin
						acc_n    = 32'(data_s1);
						len_done = 1'b1;
					end else if (data_s1[6:0] > derrsa_pkg::MAX_LEN_BYTES) begin
						fail_req  = 1'b1;
						fail_code = derrsa_pkg::STAT_LONG_LENGTH;
					end else if (data_s1[6:0] == 7'd0) begin
						acc_n    = '0;
						len_done = 1'b1;
					end else begin
						acc_n   = '0;
						lbl_n   = data_s1[2:0];
						phase_n = PH_LEN_MORE;
					end
				end
				PH_LEN_MORE: begin
					acc_n = {acc_q[23:0], data_s1};
					lbl_n = lbl_q - 3'd1;
					if (lbl_n == 3'd0) len_done = 1'b1;
				end
				PH_SKIP_BODY: begin
					skip_n = skip_q - 32'd1;
					if (skip_n == '0) skip_done = 1'b1;
				end
				PH_MOD_DATA: begin
					// The first body byte decides the size; a leading zero is dropped.
					emitted = 1'b1;
					if (skip_q == acc_q) begin
						if (data_s1 == 8'd0) begin
							eff     = acc_q - 32'd1;
							emitted = 1'b0;
						end
						too_long = ({1'b0, eff} > MOD_LIMIT);
					end
					if (too_long) begin
						emitted   = 1'b0;
						fail_req  = 1'b1;
						fail_code = derrsa_pkg::STAT_MOD_TOO_LONG;
					end else begin
						if (emitted) begin
							idx_wide                 = 32'(mcnt_q);
							push.valid               = 1'b1;
							push.item.item_kind      = derrsa_pkg::KIND_MODULUS;
							push.item.key_byte       = data_s1;
							push.item.byte_index     = idx_wide[8:0];
							mcnt_n                   = mcnt_q + 1'b1;
						end
						skip_n = skip_q - 32'd1;
						if (skip_n == '0) phase_n = PH_EXP_TAG;
					end
				end
				PH_EXP_DATA: begin
					emitted              = 1'b1;
					idx_wide             = 32'(ecnt_q);
					push.valid           = 1'b1;
					push.item.item_kind  = derrsa_pkg::KIND_EXPONENT;
					push.item.key_byte   = data_s1;
					push.item.byte_index = idx_wide[8:0];
					ecnt_n               = ecnt_q + 1'b1;
					skip_n               = skip_q - 32'd1;
					if (skip_n == '0) phase_n = PH_DONE;
				end
				default: begin
				end
			endcase

			// A length field is complete: move on according to its element.
			if (len_done) begin
				unique case (owner_q)
					OW_CERT: phase_n = PH_TBS_TAG;
					OW_TBS:  phase_n = PH_VER_TAG;
					OW_SPKI: phase_n = PH_ALG_TAG;
					OW_BIT:  phase_n = PH_UNUSED;
					OW_RSA:  phase_n = PH_MOD_TAG;
					OW_VER, OW_SKIP, OW_ALG: begin
						if (owner_q == OW_SKIP) stc_n = stc_q + 3'd1;
						skip_n = acc_n;
						if (acc_n == '0) skip_done = 1'b1;
						else             phase_n = PH_SKIP_BODY;
					end
					OW_MOD: begin
						if (acc_n == '0) begin
							phase_n = PH_EXP_TAG;
						end else if ({1'b0, acc_n} > MOD_LIMIT + 33'd1) begin
							fail_req  = 1'b1;
							fail_code = derrsa_pkg::STAT_MOD_TOO_LONG;
						end else begin
							skip_n  = acc_n;
							phase_n = PH_MOD_DATA;
						end
					end
					default: begin
						if ({1'b0, acc_n} > EXP_LIMIT) begin
							fail_req  = 1'b1;
							fail_code = derrsa_pkg::STAT_EXP_TOO_LONG;
						end else if (acc_n == '0) begin
							phase_n = PH_DONE;
						end else begin
							skip_n  = acc_n;
							phase_n = PH_EXP_DATA;
						end
					end
				endcase
			end

			// A skipped element is over.
			if (skip_done) begin
				if (owner_q == OW_ALG)                         phase_n = PH_BIT_TAG;
				else if (owner_q == OW_SKIP && stc_n >= 3'd5)  phase_n = PH_SPKI_TAG;
				else                                           phase_n = PH_SKIP_TAG;
			end

			// The first error is kept; parsing stops until the message ends.
			if (fail_req) begin
				if (err_q == derrsa_pkg::STAT_OK) err_n = fail_code;
				phase_n = PH_FAIL;
			end

			// End of message: build the status beat and return to the start.
			if (eom_s1) begin
				st = err_n;
				if (st == derrsa_pkg::STAT_OK &&
					(phase_n != PH_DONE || bc_n < 25'd6 + {1'b0, dcl_n})) begin
					st = derrsa_pkg::STAT_TRUNCATED;
				end
				mlen_wide                   = 32'(mcnt_n);
				elen_wide                   = 32'(ecnt_n);
				status_item.item_kind       = derrsa_pkg::KIND_STATUS;
				status_item.status          = st;
				status_item.modulus_length  = mlen_wide[9:0];
				status_item.exponent_length = elen_wide[3:0];
				status_item.last_of_run     = 1'b1;
				if (emitted) begin
					pend_n      = 1'b1;
					pend_item_n = status_item;
				end else begin
					push.valid = 1'b1;
					push.item  = status_item;
				end
				phase_n = PH_LIST;
				owner_n = OW_CERT;
				bc_n    = '0;
				dcl_n   = '0;
				acc_n   = '0;
				lbl_n   = '0;
				skip_n  = '0;
				stc_n   = '0;
				err_n   = derrsa_pkg::STAT_OK;
				mcnt_n  = '0;
				ecnt_n  = '0;
			end
		end
	end

	// Control and parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_q   <= 1'b0;
			phase_q  <= PH_LIST;
			owner_q  <= OW_CERT;
			bc_q     <= '0;
			dcl_q    <= '0;
			acc_q    <= '0;
			lbl_q    <= '0;
			skip_q   <= '0;
			stc_q    <= '0;
			err_q    <= derrsa_pkg::STAT_OK;
			mcnt_q   <= '0;
			ecnt_q   <= '0;
		end else begin
			valid_s1 <= accept;
			pend_q   <= pend_n;
			phase_q  <= phase_n;
			owner_q  <= owner_n;
			bc_q     <= bc_n;
			dcl_q    <= dcl_n;
			acc_q    <= acc_n;
			lbl_q    <= lbl_n;
			skip_q   <= skip_n;
			stc_q    <= stc_n;
			err_q    <= err_n;
			mcnt_q   <= mcnt_n;
			ecnt_q   <= ecnt_n;
		end
	end

	// Payload of the input register and the held status beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= bytes.data_byte;
			eom_s1  <= bytes.end_of_message;
		end
		pend_item_q <= pend_item_n;
	end

endmodule

`default_nettype wire

### design/derrsa_out_fifo.sv
`default_nettype none

module derrsa_out_fifo (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire derrsa_pkg::push_t                 push,
	output logic [derrsa_pkg::OUT_FILL_W-1:0]      fill,
	derrsa_result_if.source                        results
);

	derrsa_pkg::result_t mem [derrsa_pkg::OUT_DEPTH];

	logic [derrsa_pkg::OUT_PTR_W-1:0]  wr_ptr_q;
	logic [derrsa_pkg::OUT_PTR_W-1:0]  rd_ptr_q;
	logic [derrsa_pkg::OUT_FILL_W-1:0] fill_q;
	logic                              pop;
	derrsa_pkg::result_t               head;

	assign pop  = results.valid && results.ready;
	assign fill = fill_q;
	assign head = mem[rd_ptr_q];

	// Head entry drives the result channel.
	assign results.valid           = (fill_q != '0);
	assign results.item_kind       = head.item_kind;
	assign results.key_byte        = head.key_byte;
	assign results.byte_index      = head.byte_index;
	assign results.status          = head.status;
	assign results.modulus_length  = head.modulus_length;
	assign results.exponent_length = head.exponent_length;
	assign results.last_of_run     = head.last_of_run;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)        rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push.valid && !pop)      fill_q <= fill_q + 1'b1;
			else if (!push.valid && pop) fill_q <= fill_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.valid) mem[wr_ptr_q] <= push.item;
	end

endmodule

`default_nettype wire

### design/der_rsa_key_extractor.sv
`default_nettype none
// A result beat passes through the input register and a queue entry before it is
// offered; a status beat whose byte also yields a key byte is pushed into the queue
// in the cycle after that key byte. Bytes are taken one per cycle, but only while the
// four-entry output queue holds at most one beat and the byte that ends a message is
// not in the input register. Reset (arst_n low, asynchronous) empties the queue and
// returns the parser to the list length bytes, as does each status beat.

module der_rsa_key_extractor #(
	parameter int MODULUS_BYTES  = derrsa_pkg::MODULUS_BYTES_DEF,
	parameter int EXPONENT_BYTES = derrsa_pkg::EXPONENT_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	derrsa_byte_if.sink     bytes,
	derrsa_result_if.source results
);

	derrsa_pkg::push_t                 push;
	logic [derrsa_pkg::OUT_FILL_W-1:0] fill;

	// DER walk and key byte selection.
	derrsa_parser #(
		.MODULUS_BYTES (MODULUS_BYTES),
		.EXPONENT_BYTES(EXPONENT_BYTES)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.bytes (bytes),
		.fill  (fill),
		.push  (push)
	);

	// Result beat queue.
	derrsa_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.fill   (fill),
		.results(results)
	);

endmodule

`default_nettype wire

### tb/rsa_key_checker.sv
module rsa_key_checker (
	input  wire logic   clk,
	input  wire logic   arst_n,
	derrsa_byte_if      byte_ch,
	derrsa_result_if    result_ch,
	output int unsigned mismatches,
	output int unsigned beats_due_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MOD_LIMIT    = derrsa_pkg::MODULUS_BYTES_DEF;
	localparam int unsigned EXP_LIMIT    = derrsa_pkg::EXPONENT_BYTES_DEF;
	localparam int unsigned LIST_BYTES   = 3;
	localparam int unsigned HEADER_BYTES = 6;

	// Where the walk through the certificate stands.
	typedef enum logic [4:0] {
		P_LIST, P_CLEN, P_CERT_TAG, P_TBS_TAG, P_VER_TAG, P_SKIP_TAG, P_SPKI_TAG,
		P_ALG_TAG, P_BIT_TAG, P_UNUSED, P_RSA_TAG, P_MOD_TAG, P_MOD_DATA, P_EXP_TAG,
		P_EXP_DATA, P_LEN_FIRST, P_LEN_MORE, P_SKIP_BODY, P_DONE, P_FAIL
	} walk_phase_t;

	// Which element the length being decoded belongs to.
	typedef enum logic [3:0] {
		L_CERT, L_TBS, L_VER, L_SKIP, L_SPKI, L_ALG, L_BIT, L_RSA, L_MOD, L_EXP
	} len_owner_t;

	walk_phase_t phase;
	len_owner_t  owner;
	logic [31:0] consumed;
	logic [23:0] decl_len;
	logic [31:0] len_acc;
	logic [2:0]  len_left;
	logic [31:0] body_left;
	int unsigned tlv_count;
	logic [2:0]  err;
	int unsigned mod_cnt;
	int unsigned exp_cnt;

	derrsa_pkg::result_t beats_due[$];
	derrsa_pkg::result_t due;

	function automatic void clear_walk();
		phase     = P_LIST;
		owner     = L_CERT;
		consumed  = '0;
		decl_len  = '0;
		len_acc   = '0;
		len_left  = '0;
		body_left = '0;
		tlv_count = 0;
		err       = derrsa_pkg::STAT_OK;
		mod_cnt   = 0;
		exp_cnt   = 0;
	endfunction

	function automatic derrsa_pkg::result_t make_beat(input logic [1:0] kind,
			input logic [7:0] key, input int unsigned idx, input logic [2:0] st,
			input int unsigned ml, input int unsigned el);
		derrsa_pkg::result_t r;
		r.item_kind       = kind;
		r.key_byte        = key;
		r.byte_index      = idx[8:0];
		r.status          = st;
		r.modulus_length  = ml[9:0];
		r.exponent_length = el[3:0];
		r.last_of_run     = (kind == derrsa_pkg::KIND_STATUS);
		return r;
	endfunction

	// The first error sticks; everything up to the end of the message is ignored.
	function automatic void mark_failed(input logic [2:0] code);
		if (err == derrsa_pkg::STAT_OK) begin
			err = code;
		end
		phase = P_FAIL;
	endfunction

	function automatic void take_tag(input logic [7:0] b, input logic [7:0] tag,
			input len_owner_t who);
		if (b != tag) begin
			mark_failed(derrsa_pkg::STAT_BAD_TAG);
		end else begin
			owner = who;
			phase = P_LEN_FIRST;
		end
	endfunction

	function automatic void body_finished();
		if (owner == L_ALG) begin
			phase = P_BIT_TAG;
		end else if (owner == L_SKIP && tlv_count >= 5) begin
			phase = P_SPKI_TAG;
		end else begin
			phase = P_SKIP_TAG;
		end
	endfunction

	// A complete length decides where the walk goes next.
	function automatic void length_finished();
		case (owner)
			L_CERT: phase = P_TBS_TAG;
			L_TBS:  phase = P_VER_TAG;
			L_SPKI: phase = P_ALG_TAG;
			L_BIT:  phase = P_UNUSED;
			L_RSA:  phase = P_MOD_TAG;
			L_VER, L_SKIP, L_ALG: begin
				if (owner == L_SKIP) begin
					tlv_count++;
				end
				body_left = len_acc;
				if (body_left == 0) begin
					body_finished();
				end else begin
					phase = P_SKIP_BODY;
				end
			end
			L_MOD: begin
				if (len_acc == 0) begin
					phase = P_EXP_TAG;
				end else if (len_acc > MOD_LIMIT + 1) begin
					mark_failed(derrsa_pkg::STAT_MOD_TOO_LONG);
				end else begin
					body_left = len_acc;
					phase     = P_MOD_DATA;
				end
			end
			default: begin
				if (len_acc > EXP_LIMIT) begin
					mark_failed(derrsa_pkg::STAT_EXP_TOO_LONG);
				end else if (len_acc == 0) begin
					phase = P_DONE;
				end else begin
					body_left = len_acc;
					phase     = P_EXP_DATA;
				end
			end
		endcase
	endfunction

	// Advances the walk by one message byte and queues the beats it produces.
	function automatic void walk_certificate_byte(input logic [7:0] b, input logic eom);
		logic [31:0] eff;
		logic        keep;
		logic        first;
		logic [2:0]  st;
		if (consumed != '1) begin
			consumed++;
		end
		case (phase)
			P_LIST: begin
				if (consumed >= LIST_BYTES) begin
					phase = P_CLEN;
				end
			end
			P_CLEN: begin
				decl_len = {decl_len[15:0], b};
				if (consumed >= HEADER_BYTES) begin
					phase = P_CERT_TAG;
				end
			end
			P_CERT_TAG: take_tag(b, derrsa_pkg::TAG_SEQUENCE, L_CERT);
			P_TBS_TAG:  take_tag(b, derrsa_pkg::TAG_SEQUENCE, L_TBS);
			P_VER_TAG: begin
				owner = (b == derrsa_pkg::TAG_VERSION) ? L_VER : L_SKIP;
				phase = P_LEN_FIRST;
			end
			P_SKIP_TAG: begin
				owner = L_SKIP;
				phase = P_LEN_FIRST;
			end
			P_SPKI_TAG: take_tag(b, derrsa_pkg::TAG_SEQUENCE, L_SPKI);
			P_ALG_TAG: begin
				owner = L_ALG;
				phase = P_LEN_FIRST;
			end
			P_BIT_TAG: take_tag(b, derrsa_pkg::TAG_BIT_STRING, L_BIT);
			P_UNUSED:  phase = P_RSA_TAG;
			P_RSA_TAG: take_tag(b, derrsa_pkg::TAG_SEQUENCE, L_RSA);
			P_MOD_TAG: take_tag(b, derrsa_pkg::TAG_INTEGER, L_MOD);
			P_EXP_TAG: take_tag(b, derrsa_pkg::TAG_INTEGER, L_EXP);
			P_LEN_FIRST: begin
				if (!b[7]) begin
					len_acc = {24'd0, b};
					length_finished();
				end else if (b[6:0] > derrsa_pkg::MAX_LEN_BYTES) begin
					mark_failed(derrsa_pkg::STAT_LONG_LENGTH);
				end else if (b[6:0] == 0) begin
					// The indefinite form is read as an empty element.
					len_acc = '0;
					length_finished();
				end else begin
					len_acc  = '0;
					len_left = b[2:0];
					phase    = P_LEN_MORE;
				end
			end
			P_LEN_MORE: begin
				len_acc  = {len_acc[23:0], b};
				len_left = len_left - 3'd1;
				if (len_left == 0) begin
					length_finished();
				end
			end
			P_SKIP_BODY: begin
				body_left--;
				if (body_left == 0) begin
					body_finished();
				end
			end
			P_MOD_DATA: begin
				// The size check and the dropped leading zero apply to the first byte only.
				first = (body_left == len_acc);
				keep  = 1'b1;
				eff   = len_acc;
				if (first && b == 8'h00) begin
					eff  = len_acc - 1;
					keep = 1'b0;
				end
				if (first && eff > MOD_LIMIT) begin
					mark_failed(derrsa_pkg::STAT_MOD_TOO_LONG);
				end else begin
					if (keep) begin
						beats_due.push_back(make_beat(derrsa_pkg::KIND_MODULUS, b, mod_cnt,
							derrsa_pkg::STAT_OK, 0, 0));
						mod_cnt++;
					end
					body_left--;
					if (body_left == 0) begin
						phase = P_EXP_TAG;
					end
				end
			end
			P_EXP_DATA: begin
				beats_due.push_back(make_beat(derrsa_pkg::KIND_EXPONENT, b, exp_cnt,
					derrsa_pkg::STAT_OK, 0, 0));
				exp_cnt++;
				body_left--;
				if (body_left == 0) begin
					phase = P_DONE;
				end
			end
			default: ;
		endcase

		// The last byte of a message closes it with a status beat.
		if (eom) begin
			st = err;
			if (st == derrsa_pkg::STAT_OK && (phase != P_DONE ||
					33'(consumed) < 33'(HEADER_BYTES) + 33'(decl_len))) begin
				st = derrsa_pkg::STAT_TRUNCATED;
			end
			beats_due.push_back(make_beat(derrsa_pkg::KIND_STATUS, 8'd0, 0, st, mod_cnt,
				exp_cnt));
			clear_walk();
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Predict on every byte beat, compare on every result beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_walk();
			beats_due.delete();
			mismatches      = 0;
			beats_due_count = 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				walk_certificate_byte(byte_ch.data_byte, byte_ch.end_of_message);
			end
			if (result_ch.valid && result_ch.ready) begin
				if (beats_due.size() == 0) begin
					$error("result beat with nothing expected: kind %0h byte %0h",
						result_ch.item_kind, result_ch.key_byte);
					mismatches++;
				end else begin
					due = beats_due.pop_front();
					check_field("item_kind", due.item_kind, result_ch.item_kind);
					check_field("key_byte", due.key_byte, result_ch.key_byte);
					check_field("byte_index", due.byte_index, result_ch.byte_index);
					check_field("status", due.status, result_ch.status);
					check_field("modulus_length", due.modulus_length, result_ch.modulus_length);
					check_field("exponent_length", due.exponent_length,
						result_ch.exponent_length);
					check_field("last_of_run", due.last_of_run, result_ch.last_of_run);
				end
			end
			beats_due_count = beats_due.size();
		end
	end

endmodule

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTE_TARGET = 1300;
	localparam int IDLE_LIMIT  = 2000;

	// Ways a generated certificate is damaged.
	typedef enum int {
		FLAW_NONE, FLAW_TAG, FLAW_LENGTH, FLAW_CUT, FLAW_MOD_LONG, FLAW_EXP_LONG
	} flaw_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	derrsa_byte_if   byte_ch();
	derrsa_result_if result_ch();

	int unsigned mismatches;
	int unsigned beats_due_count;

	der_rsa_key_extractor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (result_ch)
	);

	rsa_key_checker key_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_ch         (byte_ch),
		.result_ch       (result_ch),
		.mismatches      (mismatches),
		.beats_due_count (beats_due_count)
	);

	always #10 clk = ~clk;

	logic [7:0] msg_bytes[$];
	int         tag_spots[$];
	int         len_spots[$];
	int         bytes_sent  = 0;
	int         burst_left  = 0;
	int         stall_left  = 0;
	int         stall_mode  = 0;
	int         idle_cycles = 0;

	// Result side: segments of full speed, random stalls, a duty pattern, or a hard stall.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = (stall_mode == 3) ? $urandom_range(1, 24) : $urandom_range(8, 64);
		end
		stall_left--;
		case (stall_mode)
			0:       result_ch.ready <= 1'b1;
			1:       result_ch.ready <= 1'($urandom_range(0, 1));
			2:       result_ch.ready <= (stall_left % 4) != 0;
			default: result_ch.ready <= 1'b0;
		endcase
	end

	// Ends a run that stops making progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic void add_random(input int n);
		for (int i = 0; i < n; i++) begin
			msg_bytes.push_back(8'($urandom));
		end
	endfunction

	// Encodes a DER length in a randomly chosen valid form, padded long forms included.
	function automatic void add_length(input int unsigned v);
		int n;
		int k;
		if (v < 128 && $urandom_range(0, 2) != 0) begin
			msg_bytes.push_back(v[7:0]);
		end else if (v == 0 && $urandom_range(0, 1) == 1) begin
			msg_bytes.push_back(8'h80);
		end else begin
			n = (v > 32'hFFFFFF) ? 4 : (v > 32'hFFFF) ? 3 : (v > 32'hFF) ? 2 : 1;
			k = $urandom_range(4, n);
			msg_bytes.push_back(8'h80 | 8'(k));
			for (int i = k - 1; i >= 0; i--) begin
				msg_bytes.push_back(8'(v >> (8 * i)));
			end
		end
	endfunction

	function automatic void add_header(input logic [7:0] tag, input int unsigned v,
			input bit checked);
		if (checked) begin
			tag_spots.push_back(msg_bytes.size());
		end
		msg_bytes.push_back(tag);
		len_spots.push_back(msg_bytes.size());
		add_length(v);
	endfunction

	// Container lengths are never checked, so any value will do.
	function automatic int unsigned container_len();
		return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600);
	endfunction

	// Builds one Certificate message, optionally damaged in one place.
	function automatic void build_certificate(input bit big_key, input flaw_t flaw);
		bit          has_ver;
		int          n;
		int          r;
		int          spot;
		int unsigned mod_len;
		int unsigned exp_len;
		int unsigned lead;
		int unsigned total;
		int unsigned decl;
		logic [7:0]  tag;
		msg_bytes.delete();
		tag_spots.delete();
		len_spots.delete();
		add_random(6);
		add_header(derrsa_pkg::TAG_SEQUENCE, container_len(), 1);
		add_header(derrsa_pkg::TAG_SEQUENCE, container_len(), 1);
		has_ver = 1'($urandom_range(0, 1));
		if (has_ver) begin
			n = $urandom_range(0, 5);
			add_header(derrsa_pkg::TAG_VERSION, n, 0);
			add_random(n);
		end
		for (int i = 0; i < 5; i++) begin
			tag = 8'($urandom);
			if (!has_ver && i == 0 && tag == derrsa_pkg::TAG_VERSION) begin
				tag = derrsa_pkg::TAG_INTEGER;
			end
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
			add_header(tag, n, 0);
			add_random(n);
		end
		add_header(derrsa_pkg::TAG_SEQUENCE, container_len(), 1);
		n = $urandom_range(0, 12);
		add_header(($urandom_range(0, 3) == 0) ? 8'($urandom) : derrsa_pkg::TAG_SEQUENCE,
			n, 0);
		add_random(n);
		add_header(derrsa_pkg::TAG_BIT_STRING, container_len(), 1);
		add_random(1);
		add_header(derrsa_pkg::TAG_SEQUENCE, container_len(), 1);

		// Modulus: mostly short keys, rarely the largest one.
		if (flaw == FLAW_MOD_LONG) begin
			if ($urandom_range(0, 1) == 1) begin
				add_header(derrsa_pkg::TAG_INTEGER, derrsa_pkg::MODULUS_BYTES_DEF + 1, 1);
				msg_bytes.push_back(8'($urandom_range(1, 255)));
			end else begin
				add_header(derrsa_pkg::TAG_INTEGER, ($urandom_range(0, 1) == 1) ?
					$urandom_range(derrsa_pkg::MODULUS_BYTES_DEF + 2, 70000) :
					($urandom | 32'h8000_0000), 1);
			end
			add_random($urandom_range(0, 4));
		end else begin
			r = $urandom_range(0, 99);
			if (big_key || r < 2) begin
				mod_len = derrsa_pkg::MODULUS_BYTES_DEF;
			end else if (r < 8) begin
				mod_len = 0;
			end else begin
				mod_len = $urandom_range(1, 24);
			end
			lead = big_key ? 1 : $urandom_range(0, 1);
			add_header(derrsa_pkg::TAG_INTEGER, mod_len + lead, 1);
			if (lead != 0) begin
				msg_bytes.push_back(8'h00);
			end
			add_random(mod_len);
		end

		// Exponent.
		if (flaw == FLAW_EXP_LONG) begin
			add_header(derrsa_pkg::TAG_INTEGER, ($urandom_range(0, 2) == 0) ? $urandom :
				$urandom_range(derrsa_pkg::EXPONENT_BYTES_DEF + 1, 255), 1);
			add_random($urandom_range(0, 4));
		end else begin
			r = $urandom_range(0, 99);
			exp_len = (r < 6) ? 0 : (r < 30) ? derrsa_pkg::EXPONENT_BYTES_DEF :
				$urandom_range(1, derrsa_pkg::EXPONENT_BYTES_DEF);
			add_header(derrsa_pkg::TAG_INTEGER, exp_len, 1);
			add_random(exp_len);
		end

		// Trailing bytes after the key are ignored.
		if ($urandom_range(0, 3) == 0) begin
			add_random($urandom_range(1, 4));
		end

		// Declared certificate length: usually covered, sometimes too long.
		total = msg_bytes.size();
		r     = $urandom_range(0, 19);
		if (r == 0) begin
			decl = $urandom_range(0, 24'hFFFFFF);
		end else if (r < 3) begin
			decl = total - 6 + $urandom_range(1, 200);
		end else begin
			decl = total - 6 - $urandom_range(0, 4);
		end
		msg_bytes[3] = decl[23:16];
		msg_bytes[4] = decl[15:8];
		msg_bytes[5] = decl[7:0];

		case (flaw)
			FLAW_TAG: begin
				spot = tag_spots[$urandom_range(0, tag_spots.size() - 1)];
				msg_bytes[spot] = msg_bytes[spot] ^ 8'($urandom_range(1, 255));
			end
			FLAW_LENGTH: begin
				spot = len_spots[$urandom_range(0, len_spots.size() - 1)];
				msg_bytes[spot] = 8'($urandom_range(8'h85, 8'hFF));
			end
			FLAW_CUT: begin
				n = $urandom_range(1, msg_bytes.size() - 1);
				while (msg_bytes.size() > n) begin
					void'(msg_bytes.pop_back());
				end
			end
			default: ;
		endcase
	endfunction

	// Offers one byte beat, opening a new burst after a random gap when the last one ran out.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		byte_ch.valid          <= 1'b1;
		byte_ch.data_byte      <= b;
		byte_ch.end_of_message <= last;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++) begin
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		end
	endtask

	initial begin
		int pick;
		byte_ch.valid          <= 1'b0;
		byte_ch.data_byte      <= 8'd0;
		byte_ch.end_of_message <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A message that ends on its first byte.
		msg_bytes = '{8'hFF};
		send_message();
		// Wrong certificate tag.
		msg_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h31, 8'h7F};
		send_message();
		// Five length bytes.
		msg_bytes = '{8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'h10, derrsa_pkg::TAG_SEQUENCE,
			8'h85, 8'h00};
		send_message();

		// The largest modulus with its leading zero, then a mix of clean, damaged and
		// junk messages.
		build_certificate(1, FLAW_NONE);
		send_message();
		while (bytes_sent < BYTE_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				msg_bytes.delete();
				add_random($urandom_range(1, 16));
			end else if (pick < 67) begin
				build_certificate(0, FLAW_NONE);
			end else begin
				build_certificate(0, flaw_t'($urandom_range(FLAW_TAG, FLAW_EXP_LONG)));
			end
			send_message();
		end
		byte_ch.valid <= 1'b0;

		// Drain, then wait so that any stray beat can show.
		@(negedge clk);
		while (beats_due_count != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
